// ===== hdl/assert_macros.svh =====
// Assertion helpers: active in simulation, empty in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== hdl/fisp_pkg.sv =====
package fisp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] section_address;
        logic [31:0] section_length;
        logic [15:0] section_crc;
        logic        section_crc_ok;
        logic [31:0] file_crc;
        logic        file_crc_ok;
        logic        truncated;
        logic        last_result;
    } t_out_item;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_ADDR   = 3'd1,
        PH_LEN    = 3'd2,
        PH_DATA   = 3'd3,
        PH_CRC    = 3'd4
    } t_phase;

    localparam logic [7:0] CH_OPEN  = 8'h7B;
    localparam logic [7:0] CH_CLOSE = 8'h7D;
    localparam logic       KIND_SECTION = 1'b0;
    localparam logic       KIND_FILE    = 1'b1;

    // Classified byte handed from front to back.
    // hdr_end marks the brace that closes the header.
    typedef struct packed {
        logic       in_body;
        logic       hdr_end;
        logic [7:0] data_byte;
        logic       end_of_file;
    } t_token;

    function automatic logic [31:0] crc32_byte(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] c;
        c = acc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {b, 8'd0};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ===== hdl/fisp_front.sv =====
module fisp_front #(
    parameter int DEPTH_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  fisp_pkg::t_in_item i_item,
    output fisp_pkg::t_token  o_token
);
    import fisp_pkg::*;

    logic                  r_in_body;
    logic [DEPTH_BITS-1:0] r_depth;
    logic                  n_in_body;
    logic [DEPTH_BITS-1:0] n_depth;
    logic                  hdr_end;

    always_comb begin
        n_in_body = r_in_body;
        n_depth   = r_depth;
        hdr_end   = 1'b0;
        if (!r_in_body) begin
            if (i_item.data_byte == CH_OPEN) begin
                n_depth = r_depth + 1'b1;
            end else if (i_item.data_byte == CH_CLOSE) begin
                n_depth = r_depth - 1'b1;
                if (n_depth == '0) begin
                    n_in_body = 1'b1;
                    hdr_end   = 1'b1;
                end
            end
        end
        // restart on end of file
        if (i_item.end_of_file) begin
            n_in_body = 1'b0;
            n_depth   = '0;
        end
    end

    assign o_token = '{in_body: r_in_body, hdr_end: hdr_end, data_byte: i_item.data_byte,
                       end_of_file: i_item.end_of_file};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_body <= 1'b0;
            r_depth   <= '0;
        end else if (i_valid) begin
            r_in_body <= n_in_body;
            r_depth   <= n_depth;
        end
    end
endmodule

// ===== hdl/fisp_back.sv =====
module fisp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  fisp_pkg::t_token   i_token,
    input  logic [31:0]        i_expected,
    output logic               o_sec_valid,
    output fisp_pkg::t_out_item o_sec,
    output logic               o_file_valid,
    output fisp_pkg::t_out_item o_file
);
    import fisp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_cnt, n_cnt;
    logic [31:0] r_addr, n_addr, r_len, n_len, r_rem, n_rem, r_fcrc, n_fcrc;
    logic [15:0] r_scrc, n_scrc, r_stored, n_stored;
    logic [7:0]  b;
    logic [31:0] fc;

    assign b = i_token.data_byte;

    always_comb begin
        n_phase = r_phase; n_cnt = r_cnt; n_addr = r_addr; n_len = r_len;
        n_rem = r_rem; n_fcrc = r_fcrc; n_scrc = r_scrc; n_stored = r_stored;
        o_sec_valid = 1'b0;
        o_sec = '0;
        if (!i_token.in_body) begin
            n_phase = PH_HEADER;
        end else begin
            if (r_phase == PH_HEADER) begin
                n_phase = PH_ADDR;
            end
            n_fcrc = crc32_byte(r_fcrc, b);
        end
        if (i_token.in_body) begin
            unique case (n_phase)
                PH_ADDR: begin
                    n_addr = {r_addr[23:0], b};
                    n_cnt  = r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_len = {r_len[23:0], b};
                    n_cnt = r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        n_rem   = n_len;
                        n_scrc  = 16'hFFFF;
                        n_phase = (n_len == '0) ? PH_CRC : PH_DATA;
                    end
                end
                PH_DATA: begin
                    n_scrc = crc16_byte(r_scrc, b);
                    n_rem  = r_rem - 32'd1;
                    if (n_rem == '0) begin
                        n_cnt   = 2'd0;
                        n_phase = PH_CRC;
                    end
                end
                PH_CRC: begin
                    n_stored = {r_stored[7:0], b};
                    if (r_cnt == 2'd1) begin
                        o_sec_valid = 1'b1;
                        o_sec.result_kind     = KIND_SECTION;
                        o_sec.section_address = r_addr;
                        o_sec.section_length  = r_len;
                        o_sec.section_crc     = r_scrc;
                        o_sec.section_crc_ok  = (r_scrc == n_stored);
                        o_sec.last_result     = !i_token.end_of_file;
                        n_cnt   = 2'd0;
                        n_scrc  = 16'hFFFF;
                        n_phase = PH_ADDR;
                    end else begin
                        n_cnt = 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign fc = n_fcrc ^ 32'hFFFFFFFF;
    assign o_file_valid = i_token.end_of_file;
    always_comb begin
        o_file = '0;
        o_file.result_kind = KIND_FILE;
        o_file.file_crc    = fc;
        o_file.file_crc_ok = (fc == i_expected);
        // a file that ends on the closing header brace stands between sections
        o_file.truncated   = !(i_token.hdr_end || ((n_phase == PH_ADDR) && (n_cnt == 2'd0)));
        o_file.last_result = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && i_token.end_of_file)) begin
            r_phase <= PH_HEADER; r_cnt <= '0; r_addr <= '0; r_len <= '0;
            r_rem <= '0; r_fcrc <= 32'hFFFFFFFF; r_scrc <= 16'hFFFF; r_stored <= '0;
        end else if (i_valid) begin
            r_phase <= n_phase; r_cnt <= n_cnt; r_addr <= n_addr; r_len <= n_len;
            r_rem <= n_rem; r_fcrc <= n_fcrc; r_scrc <= n_scrc; r_stored <= n_stored;
        end
    end
endmodule

// ===== hdl/fisp_queue.sv =====
module fisp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  fisp_pkg::t_token    i_data,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_empty,
    output fisp_pkg::t_token    o_data
);
    import fisp_pkg::*;

    t_token     r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 2'd1;
            if (do_pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, do_push} - {2'd0, do_pop};
        end
    end
endmodule

// ===== hdl/fisp_outq.sv =====
module fisp_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push_a,
    input  fisp_pkg::t_out_item i_a,
    input  logic                i_push_b,
    input  fisp_pkg::t_out_item i_b,
    output logic [2:0]          o_count,
    input  logic                i_pop,
    output logic                o_empty,
    output fisp_pkg::t_out_item o_data
);
    import fisp_pkg::*;

    t_out_item  r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       do_pop;
    logic [1:0] n_push;

    assign o_empty = (r_cnt == 3'd0);
    assign o_count = r_cnt;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];
    assign n_push  = {1'b0, i_push_a} + {1'b0, i_push_b};

    // two writes a cycle: section report first, file report after it
    always_ff @(posedge i_clk) begin
        if (i_push_a) begin
            r_mem[r_wp] <= i_a;
        end
        if (i_push_b) begin
            r_mem[r_wp + {1'b0, i_push_a}] <= i_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + n_push;
            if (do_pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {1'b0, n_push} - {2'd0, do_pop};
        end
    end
endmodule

// ===== hdl/flash_image_section_parser_top.sv =====
// Path: a byte is registered in the token queue, then its reports in the result queue.
// Throughput: one byte per cycle while neither queue stalls; the back end updates the
// CRC-32/CRC-16 a byte at a time, and a file report costs one extra pop slot.
// Reset: synchronous, active low; clears parse state and queues, register to 0.
// After the final byte all parse state returns to its reset values.
`include "assert_macros.svh"
module flash_image_section_parser_top #(
    parameter int DEPTH_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  fisp_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output fisp_pkg::t_out_item o_item,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_data
);
    import fisp_pkg::*;

    logic [31:0] r_expected;
    logic        accept, q_empty, q_full, back_go;
    t_token      tok_in, tok_out;
    logic        sec_v, file_v;
    t_out_item   sec_item, file_item;
    logic [2:0]  oq_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= '0;
        end else if (i_cfg_we) begin
            r_expected <= i_cfg_data;
        end
    end

    assign full   = q_full;
    assign accept = push && !q_full;

    fisp_front #(.DEPTH_BITS(DEPTH_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid(accept), .i_item, .o_token(tok_in)
    );

    fisp_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_data(tok_in), .o_full(q_full),
        .i_pop(back_go), .o_empty(q_empty), .o_data(tok_out)
    );

    // advance only when the result queue has room for two reports
    assign back_go = !q_empty && (oq_cnt <= 3'd2);

    fisp_back u_back (
        .i_clk, .i_rst_n, .i_valid(back_go), .i_token(tok_out), .i_expected(r_expected),
        .o_sec_valid(sec_v), .o_sec(sec_item), .o_file_valid(file_v), .o_file(file_item)
    );

    fisp_outq u_outq (
        .i_clk, .i_rst_n,
        .i_push_a(back_go && sec_v), .i_a(sec_item),
        .i_push_b(back_go && file_v), .i_b(file_item),
        .o_count(oq_cnt), .i_pop(pop), .o_empty(empty), .o_data(o_item)
    );

    `ASSERT_NEVER(a_outq_over, i_clk, i_rst_n, oq_cnt > 3'd4)
    `ASSERT_CLK(a_go_room, i_clk, i_rst_n, back_go |-> (oq_cnt <= 3'd2))
    `ASSERT_CLK(a_file_last, i_clk, i_rst_n,
        (!empty && o_item.result_kind == KIND_FILE) |-> o_item.last_result)
endmodule
